FILE: rtl/tgm_pkg.sv
// Shared types, constants and the button hit-test function for the touch gamepad mapper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tgm_pkg;

   localparam int NUM_LANES    = 5;
   localparam int CNT_W        = 3;
   localparam int X_W          = 9;
   localparam int Y_W          = 8;
   localparam int DZ_W         = 6;
   localparam int LAYOUT_W     = 2;
   localparam int BTN_W        = 4;
   localparam int DX_W         = X_W + 1;
   localparam int DY_W         = Y_W + 1;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = X_W;
   localparam int EXT_W        = X_W + 1;
   localparam int RECT_DIM_W   = 7;
   localparam int TABLE_DEPTH  = 5;
   localparam int LAYOUT_CODES = 4;

   localparam logic [LAYOUT_W-1:0] LAYOUT_RESET = 2'd0;
   localparam logic [X_W-1:0]      ZONE_RESET   = 9'd156;
   localparam logic [DZ_W-1:0]     DEAD_RESET   = 6'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAYOUT = 2'd0,
      CSR_ZONE   = 2'd1,
      CSR_DEAD   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_LOW    = 2'd0,
      DIR_CENTRE = 2'd1,
      DIR_HIGH   = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      ACT_BTN0  = 3'd0,
      ACT_BTN1  = 3'd1,
      ACT_BTN2  = 3'd2,
      ACT_BTN3  = 3'd3,
      ACT_MENU  = 3'd4,
      ACT_PAUSE = 3'd5,
      ACT_NONE  = 3'd6
   } act_type;

   typedef struct packed {
      logic [X_W-1:0]        left;
      logic [Y_W-1:0]        top;
      logic [RECT_DIM_W-1:0] width;
      logic [RECT_DIM_W-1:0] height;
      act_type               act;
   } rect_type;

   typedef struct packed {
      logic [BTN_W-1:0] bits;
      logic             menu;
      logic             pause;
   } hit_type;

   typedef struct packed {
      logic           stick;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      hit_type        hit;
   } lane_result_type;

   typedef struct packed {
      logic           stick;
      logic [X_W-1:0] sx;
      logic [Y_W-1:0] sy;
      hit_type        hit;
   } frame_type;

   typedef struct packed {
      logic [1:0]       vertical_dir;
      logic [1:0]       horizontal_dir;
      logic [BTN_W-1:0] button_bits;
      logic             menu_pulse;
      logic             pause_pulse;
      logic             stick_held;
      logic [X_W-1:0]   centre_x;
      logic [Y_W-1:0]   centre_y;
      logic             redraw;
   } rsp_payload_type;

   localparam rect_type RECT_PAD = '{left: 9'd0, top: 8'd0, width: 7'd0, height: 7'd0,
                                     act: ACT_NONE};

   // One row per layout code; rows are padded and only the first TABLE_COUNT entries count.
   localparam rect_type RECT_TABLE [LAYOUT_CODES][TABLE_DEPTH] = '{
      '{ '{9'd262, 8'd144, 7'd50, 7'd50, ACT_BTN0},
         '{9'd206, 8'd168, 7'd48, 7'd48, ACT_BTN1},
         '{9'd160, 8'd218, 7'd46, 7'd16, ACT_BTN2},
         '{9'd212, 8'd218, 7'd52, 7'd16, ACT_BTN3},
         '{9'd286, 8'd2,   7'd32, 7'd16, ACT_MENU} },
      '{ '{9'd252, 8'd156, 7'd58, 7'd58, ACT_BTN0},
         '{9'd160, 8'd218, 7'd46, 7'd16, ACT_BTN1},
         '{9'd212, 8'd218, 7'd52, 7'd16, ACT_BTN2},
         '{9'd286, 8'd2,   7'd32, 7'd16, ACT_MENU},
         RECT_PAD },
      '{ '{9'd262, 8'd144, 7'd50, 7'd50, ACT_BTN0},
         '{9'd206, 8'd168, 7'd48, 7'd48, ACT_BTN1},
         '{9'd178, 8'd218, 7'd62, 7'd16, ACT_PAUSE},
         '{9'd286, 8'd2,   7'd32, 7'd16, ACT_MENU},
         RECT_PAD },
      '{ RECT_PAD, RECT_PAD, RECT_PAD, RECT_PAD, RECT_PAD }
   };

   localparam logic [CNT_W-1:0] TABLE_COUNT [LAYOUT_CODES] = '{3'd5, 3'd4, 3'd4, 3'd0};

   // First matching rectangle of the selected layout wins.
   function automatic hit_type rect_hit(input logic [LAYOUT_W-1:0] layout,
                                        input logic [X_W-1:0] x,
                                        input logic [Y_W-1:0] y);
      hit_type  res;
      logic     found;
      rect_type r;
      logic     inside_x;
      logic     inside_y;
      res   = '0;
      found = 1'b0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         r        = RECT_TABLE[layout][k];
         inside_x = (x >= r.left) &&
                    (EXT_W'(x) < EXT_W'(r.left) + EXT_W'(r.width));
         inside_y = (y >= r.top) &&
                    (EXT_W'(y) < EXT_W'(r.top) + EXT_W'(r.height));
         if (!found && (CNT_W'(k) < TABLE_COUNT[layout]) && inside_x && inside_y) begin
            found = 1'b1;
            case (r.act)
               ACT_BTN0:  res.bits[0] = 1'b1;
               ACT_BTN1:  res.bits[1] = 1'b1;
               ACT_BTN2:  res.bits[2] = 1'b1;
               ACT_BTN3:  res.bits[3] = 1'b1;
               ACT_MENU:  res.menu    = 1'b1;
               ACT_PAUSE: res.pause   = 1'b1;
               default:   res         = res;
            endcase
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tgm_if.sv
// Valid/ready channel interfaces of the touch gamepad mapper: frames, results, register writes.
// Depends on tgm_pkg for the field widths.
`default_nettype none

interface tgm_req_if import tgm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] contact_count;
   logic [X_W-1:0]   x_first;
   logic [Y_W-1:0]   y_first;
   logic [X_W-1:0]   x_second;
   logic [Y_W-1:0]   y_second;
   logic [X_W-1:0]   x_third;
   logic [Y_W-1:0]   y_third;
   logic [X_W-1:0]   x_fourth;
   logic [Y_W-1:0]   y_fourth;
   logic [X_W-1:0]   x_fifth;
   logic [Y_W-1:0]   y_fifth;

   modport source (output valid, contact_count, x_first, y_first, x_second, y_second,
                   x_third, y_third, x_fourth, y_fourth, x_fifth, y_fifth,
                   input ready);
   modport sink (input valid, contact_count, x_first, y_first, x_second, y_second,
                 x_third, y_third, x_fourth, y_fourth, x_fifth, y_fifth,
                 output ready);
endinterface

interface tgm_rsp_if import tgm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       vertical_dir;
   logic [1:0]       horizontal_dir;
   logic [BTN_W-1:0] button_bits;
   logic             menu_pulse;
   logic             pause_pulse;
   logic             stick_held;
   logic [X_W-1:0]   centre_x;
   logic [Y_W-1:0]   centre_y;
   logic             redraw;

   modport source (output valid, vertical_dir, horizontal_dir, button_bits, menu_pulse,
                   pause_pulse, stick_held, centre_x, centre_y, redraw,
                   input ready);
   modport sink (input valid, vertical_dir, horizontal_dir, button_bits, menu_pulse,
                 pause_pulse, stick_held, centre_x, centre_y, redraw,
                 output ready);
endinterface

interface tgm_csr_if import tgm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tgm_lane.sv
// One contact lane: classifies a contact as stick input or hit-tests it against the button table.
// Depends on tgm_pkg.
`default_nettype none

module tgm_lane import tgm_pkg::*; (
   input  wire logic                enable,
   input  wire logic [X_W-1:0]      x,
   input  wire logic [Y_W-1:0]      y,
   input  wire logic [X_W-1:0]      zone_limit,
   input  wire logic [LAYOUT_W-1:0] layout,
   output lane_result_type          result
);

   logic in_zone;

   assign in_zone = x < zone_limit;

   always_comb begin
      result       = '0;
      result.x     = x;
      result.y     = y;
      result.stick = enable && in_zone;
      if (enable && !in_zone) begin
         result.hit = rect_hit(layout, x, y);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tgm_merge.sv
// Merging stage: ORs the button hits of all lanes and keeps the last stick contact.
// Depends on tgm_pkg.
`default_nettype none

module tgm_merge import tgm_pkg::*; (
   input  wire lane_result_type lanes [NUM_LANES],
   output frame_type            frame
);

   always_comb begin
      frame = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         frame.hit.bits  = frame.hit.bits | lanes[i].hit.bits;
         frame.hit.menu  = frame.hit.menu | lanes[i].hit.menu;
         frame.hit.pause = frame.hit.pause | lanes[i].hit.pause;
         // Later contacts override earlier ones for the stick position.
         if (lanes[i].stick) begin
            frame.stick = 1'b1;
            frame.sx    = lanes[i].x;
            frame.sy    = lanes[i].y;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/touch_gamepad_mapper.sv
// Top level of the touch gamepad mapper: lanes, merge, stick and edge state, result queue.
// Depends on tgm_pkg, tgm_if, tgm_lane and tgm_merge.
//
// Usage: each beat on req_bus is one touch frame with a contact count and five contact
// positions. Each accepted frame yields exactly one beat on rsp_bus carrying the stick
// directions, button bits, menu/pause pulses, stick state, latched centre and redraw flag.
// csr_bus writes the layout select (index 0), stick zone limit (index 1) and dead zone
// (index 2); it is always ready and other indexes are ignored. Write it only while idle.
// Each result is registered in the queue and reaches rsp_bus after earlier beats leave.
// Throughput: one frame per cycle while the queue is not full. Five lanes test the contacts
// side by side and all state updates happen in the accept cycle, so the rate is set by that
// single stage. A two-entry result queue sits between the stage and rsp_bus; req_bus.ready is a
// register (queue not full), so a stalled receiver stops input after two waiting beats.
// Reset (synchronous, active high) empties the queue, restores the register defaults
// and clears the stick, pulse-edge and redraw history.
`default_nettype none

module touch_gamepad_mapper import tgm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tgm_req_if.sink    req_bus,
   tgm_rsp_if.source  rsp_bus,
   tgm_csr_if.sink    csr_bus
);

   // Configuration registers.
   logic [LAYOUT_W-1:0] layout_ff;
   logic [X_W-1:0]      zone_ff;
   logic [DZ_W-1:0]     dead_ff;

   // Frame-to-frame state.
   logic                held_ff, held_in;
   logic [X_W-1:0]      centre_x_ff, centre_x_in;
   logic [Y_W-1:0]      centre_y_ff, centre_y_in;
   logic                menu_was_ff, pause_was_ff;
   rsp_payload_type     last_ff, last_in;

   // Result queue.
   rsp_payload_type     entry_ff [2];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          cnt_ff;

   logic                push, pop;
   logic [X_W-1:0]      cx [NUM_LANES];
   logic [Y_W-1:0]      cy [NUM_LANES];
   lane_result_type     lanes [NUM_LANES];
   frame_type           frame;
   rsp_payload_type     result;
   logic signed [DX_W-1:0] dx, dz_x;
   logic signed [DY_W-1:0] dy, dz_y;
   logic                changed;

   assign cx[0] = req_bus.x_first;
   assign cy[0] = req_bus.y_first;
   assign cx[1] = req_bus.x_second;
   assign cy[1] = req_bus.y_second;
   assign cx[2] = req_bus.x_third;
   assign cy[2] = req_bus.y_third;
   assign cx[3] = req_bus.x_fourth;
   assign cy[3] = req_bus.y_fourth;
   assign cx[4] = req_bus.x_fifth;
   assign cy[4] = req_bus.y_fifth;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      tgm_lane u_lane (
         .enable     (CNT_W'(i) < req_bus.contact_count),
         .x          (cx[i]),
         .y          (cy[i]),
         .zone_limit (zone_ff),
         .layout     (layout_ff),
         .result     (lanes[i])
      );
   end

   tgm_merge u_merge (
      .lanes (lanes),
      .frame (frame)
   );

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_RESET;
         zone_ff   <= ZONE_RESET;
         dead_ff   <= DEAD_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_LAYOUT: layout_ff <= csr_bus.data[LAYOUT_W-1:0];
            CSR_ZONE:   zone_ff   <= csr_bus.data[X_W-1:0];
            CSR_DEAD:   dead_ff   <= csr_bus.data[DZ_W-1:0];
            default:    layout_ff <= layout_ff;
         endcase
      end
   end

   // Stick, direction, pulse and redraw evaluation for the frame on req_bus.
   always_comb begin
      held_in     = frame.stick;
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      if (frame.stick && !held_ff) begin
         centre_x_in = frame.sx;
         centre_y_in = frame.sy;
      end
      dx   = $signed({1'b0, frame.sx}) - $signed({1'b0, centre_x_in});
      dy   = $signed({1'b0, frame.sy}) - $signed({1'b0, centre_y_in});
      dz_x = $signed(DX_W'(dead_ff));
      dz_y = $signed(DY_W'(dead_ff));

      result                = '0;
      result.horizontal_dir = DIR_CENTRE;
      result.vertical_dir   = DIR_CENTRE;
      if (frame.stick) begin
         if (dx < -dz_x) begin
            result.horizontal_dir = DIR_LOW;
         end else if (dx > dz_x) begin
            result.horizontal_dir = DIR_HIGH;
         end
         if (dy < -dz_y) begin
            result.vertical_dir = DIR_LOW;
         end else if (dy > dz_y) begin
            result.vertical_dir = DIR_HIGH;
         end
      end
      result.button_bits = frame.hit.bits;
      result.menu_pulse  = frame.hit.menu && !menu_was_ff;
      result.pause_pulse = frame.hit.pause && !pause_was_ff;
      result.stick_held  = held_in;
      result.centre_x    = centre_x_in;
      result.centre_y    = centre_y_in;

      changed = (result.vertical_dir != last_ff.vertical_dir) ||
                (result.horizontal_dir != last_ff.horizontal_dir) ||
                (result.button_bits != last_ff.button_bits) ||
                (result.stick_held != last_ff.stick_held) ||
                (result.centre_x != last_ff.centre_x) ||
                (result.centre_y != last_ff.centre_y);
      result.redraw = changed;

      // The recorded state equals the new state whether or not it changed.
      last_in             = result;
      last_in.menu_pulse  = 1'b0;
      last_in.pause_pulse = 1'b0;
      last_in.redraw      = 1'b0;
   end

   assign req_bus.ready = !cnt_ff[1];
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         centre_x_ff  <= '0;
         centre_y_ff  <= '0;
         menu_was_ff  <= 1'b0;
         pause_was_ff <= 1'b0;
         last_ff      <= '{vertical_dir: DIR_CENTRE, horizontal_dir: DIR_CENTRE, default: '0};
      end else if (push) begin
         held_ff      <= held_in;
         centre_x_ff  <= centre_x_in;
         centre_y_ff  <= centre_y_in;
         menu_was_ff  <= frame.hit.menu;
         pause_was_ff <= frame.hit.pause;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_bus.valid          = cnt_ff != 2'd0;
   assign rsp_bus.vertical_dir   = entry_ff[rd_ptr_ff].vertical_dir;
   assign rsp_bus.horizontal_dir = entry_ff[rd_ptr_ff].horizontal_dir;
   assign rsp_bus.button_bits    = entry_ff[rd_ptr_ff].button_bits;
   assign rsp_bus.menu_pulse     = entry_ff[rd_ptr_ff].menu_pulse;
   assign rsp_bus.pause_pulse    = entry_ff[rd_ptr_ff].pause_pulse;
   assign rsp_bus.stick_held     = entry_ff[rd_ptr_ff].stick_held;
   assign rsp_bus.centre_x       = entry_ff[rd_ptr_ff].centre_x;
   assign rsp_bus.centre_y       = entry_ff[rd_ptr_ff].centre_y;
   assign rsp_bus.redraw         = entry_ff[rd_ptr_ff].redraw;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !push |=> $stable(held_ff) && $stable(centre_x_ff) && $stable(centre_y_ff))
      else $error("stick state changed without an accepted frame");

   a_no_redraw_stable: assert property (@(posedge clock) disable iff (reset)
      push && !changed |=> $stable(last_ff))
      else $error("recorded display state changed without redraw");

   a_released_centre: assert property (@(posedge clock) disable iff (reset)
      push && !frame.stick |-> result.horizontal_dir == DIR_CENTRE &&
                               result.vertical_dir == DIR_CENTRE)
      else $error("direction reported while the stick is released");
`endif

endmodule

`default_nettype wire

FILE: verif/tgm_check_pkg.sv
// Frame type, button map and result scoreboard for the touch gamepad mapper testbench.
// Depends on tgm_pkg for field widths, direction codes, action codes and register indexes.
package tgm_check_pkg;
   import tgm_pkg::*;

   localparam logic [LAYOUT_W-1:0]  LAYOUT_NES   = 2'd0;
   localparam logic [LAYOUT_W-1:0]  LAYOUT_ATARI = 2'd1;
   localparam logic [LAYOUT_W-1:0]  LAYOUT_SMS   = 2'd2;
   localparam logic [LAYOUT_W-1:0]  LAYOUT_NONE  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE    = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0]              count;
      logic [NUM_LANES-1:0][X_W-1:0] x;
      logic [NUM_LANES-1:0][Y_W-1:0] y;
   } touch_frame_type;

   typedef struct packed {
      int      left;
      int      top;
      int      w;
      int      h;
      act_type act;
   } key_rect_type;

   localparam key_rect_type KEY_PAD = '{0, 0, 0, 0, ACT_NONE};

   // Button rectangles per layout; the first hit in list order wins.
   localparam key_rect_type KEY_MAP [4][5] = '{
      '{ '{262, 144, 50, 50, ACT_BTN0}, '{206, 168, 48, 48, ACT_BTN1},
         '{160, 218, 46, 16, ACT_BTN2}, '{212, 218, 52, 16, ACT_BTN3},
         '{286, 2, 32, 16, ACT_MENU} },
      '{ '{252, 156, 58, 58, ACT_BTN0}, '{160, 218, 46, 16, ACT_BTN1},
         '{212, 218, 52, 16, ACT_BTN2}, '{286, 2, 32, 16, ACT_MENU}, KEY_PAD },
      '{ '{262, 144, 50, 50, ACT_BTN0}, '{206, 168, 48, 48, ACT_BTN1},
         '{178, 218, 62, 16, ACT_PAUSE}, '{286, 2, 32, 16, ACT_MENU}, KEY_PAD },
      '{ KEY_PAD, KEY_PAD, KEY_PAD, KEY_PAD, KEY_PAD }
   };
   localparam int KEY_COUNT [4] = '{5, 4, 4, 0};

   class controller_scoreboard;
      logic [LAYOUT_W-1:0] layout;
      logic [X_W-1:0]      zone;
      logic [DZ_W-1:0]     dead;
      logic                held;
      logic                menu_was;
      logic                pause_was;
      logic [X_W-1:0]      centre_x;
      logic [Y_W-1:0]      centre_y;
      logic [1:0]          last_vertical;
      logic [1:0]          last_horizontal;
      logic [BTN_W-1:0]    last_buttons;
      logic                last_held;
      logic [X_W-1:0]      last_centre_x;
      logic [Y_W-1:0]      last_centre_y;
      rsp_payload_type     expected_controls[$];
      int                  errors;
      int                  compared;

      function new();
         layout = LAYOUT_RESET;
         zone = ZONE_RESET;
         dead = DEAD_RESET;
         held = 1'b0;
         menu_was = 1'b0;
         pause_was = 1'b0;
         centre_x = '0;
         centre_y = '0;
         last_vertical = DIR_CENTRE;
         last_horizontal = DIR_CENTRE;
         last_buttons = '0;
         last_held = 1'b0;
         last_centre_x = '0;
         last_centre_y = '0;
         errors = 0;
         compared = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LAYOUT: layout = data[LAYOUT_W-1:0];
            CSR_ZONE:   zone = data[X_W-1:0];
            CSR_DEAD:   dead = data[DZ_W-1:0];
            default:    ;
         endcase
      endfunction

      function act_type key_under(int x, int y);
         key_rect_type r;
         for (int k = 0; k < KEY_COUNT[layout]; k++) begin
            r = KEY_MAP[layout][k];
            if (x >= r.left && x < r.left + r.w && y >= r.top && y < r.top + r.h)
               return r.act;
         end
         return ACT_NONE;
      endfunction

      // Works out the controller state that one accepted frame produces.
      function void take_frame(touch_frame_type f);
         rsp_payload_type  want;
         int               n;
         int               tx;
         int               ty;
         int               sx;
         int               sy;
         int               dx;
         int               dy;
         int               dz;
         logic             stick;
         logic             menu;
         logic             pause;
         logic [BTN_W-1:0] bits;
         dir_type          vdir;
         dir_type          hdir;
         act_type          act;
         n = (f.count > NUM_LANES) ? NUM_LANES : int'(f.count);
         stick = 1'b0;
         menu = 1'b0;
         pause = 1'b0;
         bits = '0;
         sx = 0;
         sy = 0;
         vdir = DIR_CENTRE;
         hdir = DIR_CENTRE;
         for (int i = 0; i < n; i++) begin
            tx = f.x[i];
            ty = f.y[i];
            if (tx < int'(zone)) begin
               // A later contact in the stick zone replaces an earlier one.
               stick = 1'b1;
               sx = tx;
               sy = ty;
            end else begin
               act = key_under(tx, ty);
               case (act)
                  ACT_MENU:  menu = 1'b1;
                  ACT_PAUSE: pause = 1'b1;
                  ACT_NONE:  ;
                  default:   bits = bits | (BTN_W'(1) << act);
               endcase
            end
         end
         if (stick) begin
            if (!held) begin
               held = 1'b1;
               centre_x = X_W'(sx);
               centre_y = Y_W'(sy);
            end
            dx = sx - int'(centre_x);
            dy = sy - int'(centre_y);
            dz = int'(dead);
            if (dx < -dz) hdir = DIR_LOW;
            else if (dx > dz) hdir = DIR_HIGH;
            if (dy < -dz) vdir = DIR_LOW;
            else if (dy > dz) vdir = DIR_HIGH;
         end else begin
            held = 1'b0;
         end
         want.menu_pulse = menu && !menu_was;
         want.pause_pulse = pause && !pause_was;
         menu_was = menu;
         pause_was = pause;
         want.redraw = 1'b0;
         if (vdir != last_vertical || hdir != last_horizontal || bits != last_buttons ||
             held != last_held || centre_x != last_centre_x || centre_y != last_centre_y) begin
            last_vertical = vdir;
            last_horizontal = hdir;
            last_buttons = bits;
            last_held = held;
            last_centre_x = centre_x;
            last_centre_y = centre_y;
            want.redraw = 1'b1;
         end
         want.vertical_dir = vdir;
         want.horizontal_dir = hdir;
         want.button_bits = bits;
         want.stick_held = held;
         want.centre_x = centre_x;
         want.centre_y = centre_y;
         expected_controls.push_back(want);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_controls(rsp_payload_type seen);
         rsp_payload_type want;
         if (expected_controls.size() == 0) begin
            $error("controller beat arrived with no frame outstanding");
            errors++;
            return;
         end
         want = expected_controls.pop_front();
         compared++;
         check_field("vertical_dir", want.vertical_dir, seen.vertical_dir);
         check_field("horizontal_dir", want.horizontal_dir, seen.horizontal_dir);
         check_field("button_bits", want.button_bits, seen.button_bits);
         check_field("menu_pulse", want.menu_pulse, seen.menu_pulse);
         check_field("pause_pulse", want.pause_pulse, seen.pause_pulse);
         check_field("stick_held", want.stick_held, seen.stick_held);
         check_field("centre_x", want.centre_x, seen.centre_x);
         check_field("centre_y", want.centre_y, seen.centre_y);
         check_field("redraw", want.redraw, seen.redraw);
      endfunction
   endclass

endpackage

FILE: verif/tb_touch_gamepad_mapper.sv
// Testbench top for touch_gamepad_mapper: drives touch frames and register writes, and
// checks every controller beat against the scoreboard. Depends on tgm_pkg, tgm_if,
// the block itself and tgm_check_pkg.
module tb_touch_gamepad_mapper;
   timeunit 1ns;
   timeprecision 1ps;
   import tgm_pkg::*;
   import tgm_check_pkg::*;

   localparam int NUM_SETTINGS = 10;
   localparam int PHASE_FRAMES = 183;
   localparam int HOLD_CYCLES  = 80;
   localparam int QUIET_LIMIT  = 2000;

   logic clock;
   logic reset;

   tgm_req_if req_bus ();
   tgm_rsp_if rsp_bus ();
   tgm_csr_if csr_bus ();

   touch_gamepad_mapper dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   controller_scoreboard board;
   int frames_sent = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic touch_frame_type make_touch(int count, int xa = 0, int ya = 0,
                                                  int xb = 0, int yb = 0, int xc = 0,
                                                  int yc = 0, int xd = 0, int yd = 0,
                                                  int xe = 0, int ye = 0);
      touch_frame_type f;
      f.count = CNT_W'(count);
      f.x[0] = X_W'(xa);
      f.y[0] = Y_W'(ya);
      f.x[1] = X_W'(xb);
      f.y[1] = Y_W'(yb);
      f.x[2] = X_W'(xc);
      f.y[2] = Y_W'(yc);
      f.x[3] = X_W'(xd);
      f.y[3] = Y_W'(yd);
      f.x[4] = X_W'(xe);
      f.y[4] = Y_W'(ye);
      return f;
   endfunction

   // Valid stays high from one beat to the next when no gap is wanted.
   task automatic send_frame(touch_frame_type f, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.contact_count <= f.count;
      req_bus.x_first <= f.x[0];
      req_bus.y_first <= f.y[0];
      req_bus.x_second <= f.x[1];
      req_bus.y_second <= f.y[1];
      req_bus.x_third <= f.x[2];
      req_bus.y_third <= f.y[2];
      req_bus.x_fourth <= f.x[3];
      req_bus.y_fourth <= f.y[3];
      req_bus.x_fifth <= f.x[4];
      req_bus.y_fifth <= f.y[4];
      do @(posedge clock); while (!req_bus.ready);
      board.take_frame(f);
      frames_sent++;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_reg(idx, data);
   endtask

   // With junk set, the unused upper data bits of the narrow registers carry noise.
   task automatic write_settings(logic [LAYOUT_W-1:0] lay, logic [X_W-1:0] zone,
                                 logic [DZ_W-1:0] dead, bit junk, bit spare);
      logic [CSR_DATA_W-1:0] lay_data;
      logic [CSR_DATA_W-1:0] dead_data;
      lay_data = CSR_DATA_W'(lay);
      dead_data = CSR_DATA_W'(dead);
      if (junk) begin
         lay_data[CSR_DATA_W-1:LAYOUT_W] = (CSR_DATA_W - LAYOUT_W)'($urandom);
         dead_data[CSR_DATA_W-1:DZ_W] = (CSR_DATA_W - DZ_W)'($urandom);
      end
      if (spare) csr_write(CSR_SPARE, '1);
      csr_write(CSR_LAYOUT, lay_data);
      csr_write(CSR_ZONE, zone);
      csr_write(CSR_DEAD, dead_data);
      csr_bus.valid <= 1'b0;
   endtask

   // One press: a drifting stick contact, a few held buttons and some stray contacts.
   task automatic play_gesture();
      int              len;
      int              sx;
      int              sy;
      int              span;
      int              lim;
      int              np;
      int              j;
      int              tmp;
      int              nkeys;
      int              base;
      int              roll;
      int              gap;
      int              px [8];
      int              py [8];
      int              kx [3];
      int              ky [3];
      bit              stick_on;
      bit              calm;
      logic [LAYOUT_W-1:0] lay;
      touch_frame_type f;
      key_rect_type    r;
      len = $urandom_range(1, 12);
      lim = board.zone;
      stick_on = (lim > 0) && ($urandom_range(0, 3) != 0);
      sx = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
      sy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 239);
      span = int'(board.dead) + 6;
      calm = ($urandom_range(0, 4) == 0);
      // With no buttons mapped, aim at the usual spots anyway.
      lay = (KEY_COUNT[board.layout] > 0) ? board.layout : LAYOUT_NES;
      nkeys = $urandom_range(0, 3);
      for (int k = 0; k < nkeys; k++) begin
         r = KEY_MAP[lay][$urandom_range(0, KEY_COUNT[lay] - 1)];
         kx[k] = r.left + $urandom_range(0, r.w - 1);
         ky[k] = r.top + $urandom_range(0, r.h - 1);
         case ($urandom_range(0, 7))
            0: kx[k] = r.left + r.w;
            1: ky[k] = r.top + r.h;
            2: begin
               kx[k] = r.left;
               ky[k] = r.top;
            end
            3: begin
               kx[k] = r.left + r.w - 1;
               ky[k] = r.top + r.h - 1;
            end
            default: ;
         endcase
      end
      repeat (len) begin
         np = 0;
         if (stick_on) begin
            sx = sx + int'($urandom_range(0, 2 * span)) - span;
            sy = sy + int'($urandom_range(0, 2 * span)) - span;
            sx = (sx < 0) ? 0 : (sx > 511) ? 511 : sx;
            sy = (sy < 0) ? 0 : (sy > 255) ? 255 : sy;
            if ($urandom_range(0, 14) != 0) begin
               px[np] = sx;
               py[np] = sy;
               np++;
            end
            if ($urandom_range(0, 7) == 0) begin
               px[np] = $urandom_range(0, lim - 1);
               py[np] = $urandom_range(0, 239);
               np++;
            end
         end
         for (int k = 0; k < nkeys; k++) begin
            if ($urandom_range(0, 9) < 8) begin
               px[np] = kx[k];
               py[np] = ky[k];
               np++;
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            px[np] = $urandom_range(0, 511);
            py[np] = $urandom_range(0, 255);
            np++;
         end
         for (int i = np - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = px[i];
            px[i] = px[j];
            px[j] = tmp;
            tmp = py[i];
            py[i] = py[j];
            py[j] = tmp;
         end
         for (int i = 0; i < NUM_LANES; i++) begin
            f.x[i] = (i < np) ? X_W'(px[i]) : X_W'($urandom_range(0, 511));
            f.y[i] = (i < np) ? Y_W'(py[i]) : Y_W'($urandom_range(0, 255));
         end
         base = (np > NUM_LANES) ? NUM_LANES : np;
         roll = $urandom_range(0, 19);
         if (roll < 2) f.count = CNT_W'($urandom_range(base, 7));
         else if (roll == 2) f.count = CNT_W'($urandom_range(0, base));
         else f.count = CNT_W'(base);
         gap = (calm || hold_request || hold_left > 0) ? 0 : pick_gap();
         send_frame(f, gap);
      end
   endtask

   initial begin : stimulus
      logic [LAYOUT_W-1:0] lay;
      logic [X_W-1:0]      zone;
      logic [DZ_W-1:0]     dead;
      int                  phase_start;
      bit                  held_off;
      board = new();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.contact_count <= '0;
      req_bus.x_first <= '0;
      req_bus.y_first <= '0;
      req_bus.x_second <= '0;
      req_bus.y_second <= '0;
      req_bus.x_third <= '0;
      req_bus.y_third <= '0;
      req_bus.x_fourth <= '0;
      req_bus.y_fourth <= '0;
      req_bus.x_fifth <= '0;
      req_bus.y_fifth <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_LAYOUT;
      csr_bus.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset settings.
      send_frame(make_touch(0), pick_gap());
      send_frame(make_touch(7, 511, 255, 511, 255, 511, 255, 511, 255, 511, 255), pick_gap());
      send_frame(make_touch(1, 100, 100), pick_gap());
      send_frame(make_touch(1, 106, 100), pick_gap());
      send_frame(make_touch(1, 105, 95), pick_gap());
      send_frame(make_touch(1, 94, 94), pick_gap());
      send_frame(make_touch(1, 100, 106), pick_gap());
      send_frame(make_touch(2, 0, 0, 155, 239), pick_gap());
      send_frame(make_touch(0), pick_gap());
      send_frame(make_touch(1, 0, 0), pick_gap());
      send_frame(make_touch(1, 156, 0), pick_gap());
      send_frame(make_touch(1, 262, 144), pick_gap());
      send_frame(make_touch(1, 311, 193), pick_gap());
      send_frame(make_touch(1, 312, 194), pick_gap());
      send_frame(make_touch(1, 206, 168), pick_gap());
      send_frame(make_touch(1, 160, 218), pick_gap());
      send_frame(make_touch(1, 212, 218), pick_gap());
      send_frame(make_touch(1, 286, 2), pick_gap());
      send_frame(make_touch(1, 317, 17), pick_gap());
      send_frame(make_touch(0), pick_gap());
      send_frame(make_touch(5, 262, 144, 206, 168, 160, 218, 212, 218, 286, 2), pick_gap());
      send_frame(make_touch(6, 10, 10, 300, 160, 286, 5, 0, 0, 150, 239), pick_gap());
      send_frame(make_touch(3, 300, 255, 511, 0, 0, 255), pick_gap());

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         req_bus.valid <= 1'b0;
         while (board.expected_controls.size() != 0) @(posedge clock);
         case (p)
            0: begin
               lay = LAYOUT_ATARI;
               zone = 0;
               dead = 0;
            end
            1: begin
               lay = LAYOUT_SMS;
               zone = 319;
               dead = 63;
            end
            2: begin
               lay = LAYOUT_NONE;
               zone = 156;
               dead = 5;
            end
            3: begin
               lay = LAYOUT_NES;
               zone = 511;
               dead = 1;
            end
            4: begin
               lay = LAYOUT_SMS;
               zone = 160;
               dead = 0;
            end
            default: begin
               lay = LAYOUT_W'($urandom_range(0, 3));
               zone = ($urandom_range(0, 5) == 0) ? X_W'($urandom_range(0, 511))
                                                  : X_W'($urandom_range(0, 319));
               dead = DZ_W'($urandom_range(0, 63));
            end
         endcase
         write_settings(lay, zone, dead, p >= 5, p == 0);
         phase_start = frames_sent;
         held_off = 1'b0;
         while (frames_sent - phase_start < PHASE_FRAMES) begin
            // Starve the result side for a while so the block backs up into its input.
            if (p % 3 == 1 && !held_off && frames_sent - phase_start >= 60) begin
               hold_request = 1'b1;
               held_off = 1'b1;
            end
            play_gesture();
         end
      end

      req_bus.valid <= 1'b0;
      while (board.expected_controls.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Ran %0d touch frames under %0d register settings, all four layouts among them;",
               frames_sent, NUM_SETTINGS + 1);
      $display("%0d controller beats were compared field by field.", board.compared);
      if (board.errors == 0 && board.expected_controls.size() == 0)
         $display("touch_gamepad_mapper: match");
      else
         $display("touch_gamepad_mapper: mismatch");
      $finish;
   end

   initial begin : receiver
      rsp_payload_type seen;
      int              stall;
      int              calm_left;
      bit              calm;
      stall = 0;
      calm_left = 0;
      calm = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen.vertical_dir = rsp_bus.vertical_dir;
            seen.horizontal_dir = rsp_bus.horizontal_dir;
            seen.button_bits = rsp_bus.button_bits;
            seen.menu_pulse = rsp_bus.menu_pulse;
            seen.pause_pulse = rsp_bus.pause_pulse;
            seen.stick_held = rsp_bus.stick_held;
            seen.centre_x = rsp_bus.centre_x;
            seen.centre_y = rsp_bus.centre_y;
            seen.redraw = rsp_bus.redraw;
            board.check_controls(seen);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
         if (calm_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 200);
         end else begin
            calm_left--;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("No beat on any channel for %0d cycles.", QUIET_LIMIT);
      $display("touch_gamepad_mapper: mismatch");
      $finish;
   end

endmodule
